// ===== src/cartridge_bank_mapper_irq_unit_macros.svh =====
// Assertion macros shared by the checker.
`ifndef CARTRIDGE_BANK_MAPPER_IRQ_UNIT_MACROS_SVH
`define CARTRIDGE_BANK_MAPPER_IRQ_UNIT_MACROS_SVH

// same-cycle implication, off during reset
`define CBMIRQ_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cbmirq assertion failed");

// next-cycle implication, off during reset
`define CBMIRQ_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cbmirq assertion failed");

`endif

// ===== src/cbmirq_pkg.sv =====
`default_nettype none
package cbmirq_pkg;

  typedef logic [1:0]  kind_t;
  typedef logic [15:0] addr_t;
  typedef logic [7:0]  byte_t;
  typedef logic [16:0] offset_t;
  typedef logic [12:0] count_t;

  localparam kind_t KIND_WRITE  = 2'd0;
  localparam kind_t KIND_TICK   = 2'd1;
  localparam kind_t KIND_LOOKUP = 2'd2;

  localparam addr_t DECODE_MASK = 16'hD160;
  localparam addr_t DECODE_IRQ  = 16'h4120;
  localparam addr_t DECODE_BANK = 16'h4020;
  localparam addr_t DECODE_LO   = 16'h4020;
  localparam addr_t DECODE_HI   = 16'h5FFF;
  localparam addr_t MODE_ADDR   = 16'h8000;
  localparam addr_t LOOKUP_LO   = 16'h6000;

  localparam logic [2:0] FIXED_LOW_BANK = 3'h7;
  localparam logic [2:0] FIXED_TOP_BANK = 3'h3;

  // Program address to ROM offset; caller guarantees addr >= 0x6000.
  function automatic offset_t map_offset(addr_t addr, byte_t mode, logic [2:0] sbank);
    logic [2:0] p;
    logic [2:0] bank;
    offset_t    off;
    p    = {mode[3], mode[7], mode[5]};
    bank = FIXED_TOP_BANK;
    if (!addr[15]) begin
      off = {1'b0, FIXED_LOW_BANK, addr[12:0]};
    end else if (mode[3]) begin
      unique case (mode[7:6])
        2'd0:    off = {p, 1'b0, addr[12:0]};
        2'd1:    off = {p, addr[13:0]};
        default: off = {p[2:1], addr[14:0]};
      endcase
    end else begin
      unique case (addr[14:13])
        2'd0:    bank = 3'd0;
        2'd1:    bank = 3'd1;
        2'd2:    bank = sbank;
        default: bank = FIXED_TOP_BANK;
      endcase
      off = {1'b0, bank, addr[12:0]};
    end
    return off;
  endfunction

endpackage
`default_nettype wire

// ===== src/cartridge_bank_mapper_irq_unit.sv =====
// Each item passes through the input register and then the result register.
// Accepts one item per cycle unless in_stall; result reg decouples the two sides.
// in_stall rises only while both the input and result registers hold items
// and out_stall is high.
// Reset (synchronous, rst_n low) clears both valid flags and all mapper state.
`default_nettype none
module cartridge_bank_mapper_irq_unit (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_stall,
  input  cbmirq_pkg::kind_t     in_kind,
  input  cbmirq_pkg::addr_t     in_bus_address,
  input  cbmirq_pkg::byte_t     in_write_data,
  input  cbmirq_pkg::byte_t     in_cycle_count,
  output logic                  out_valid,
  input  wire                   out_stall,
  output cbmirq_pkg::offset_t   out_rom_offset,
  output logic                  out_offset_valid,
  output logic [1:0]            out_pattern_bank,
  output logic                  out_mirror_vertical,
  output logic                  out_irq_line
);
  import cbmirq_pkg::*;

  logic    s1_v_r;
  kind_t   s1_kind_r;
  addr_t   s1_addr_r;
  byte_t   s1_data_r;
  byte_t   s1_cyc_r;

  byte_t      mode_r,     mode_nxt;
  logic [2:0] sbank_r,    sbank_nxt;
  logic       irq_en_r,   irq_en_nxt;
  count_t     irq_cnt_r,  irq_cnt_nxt;
  logic       irq_pend_r, irq_pend_nxt;

  logic    out_v_r;
  offset_t off_r,   off_nxt;
  logic    offv_r,  offv_nxt;

  logic  s1_go;
  logic  in_take;
  addr_t sel;

  assign s1_go   = s1_v_r && (!out_v_r || !out_stall);
  assign in_stall = s1_v_r && out_v_r && out_stall;
  assign in_take = in_valid && !in_stall;
  assign sel     = s1_addr_r & DECODE_MASK;

  always_comb begin
    mode_nxt     = mode_r;
    sbank_nxt    = sbank_r;
    irq_en_nxt   = irq_en_r;
    irq_cnt_nxt  = irq_cnt_r;
    irq_pend_nxt = irq_pend_r;
    off_nxt      = '0;
    offv_nxt     = 1'b0;
    unique case (s1_kind_r)
      KIND_WRITE: begin
        if (s1_addr_r >= DECODE_LO && s1_addr_r <= DECODE_HI) begin
          if (sel == DECODE_IRQ) begin
            irq_en_nxt   = s1_data_r[0];
            irq_pend_nxt = 1'b0;
            if (!s1_data_r[0]) irq_cnt_nxt = '0;
          end else if (sel == DECODE_BANK) begin
            sbank_nxt = {s1_data_r[0], s1_data_r[2:1]};
          end
        end else if (s1_addr_r == MODE_ADDR) begin
          mode_nxt = s1_data_r;
        end
      end
      KIND_TICK: begin
        if (irq_en_r) begin
          // counter below 4096 means bit 12 still clear
          if (!irq_cnt_r[12]) begin
            irq_cnt_nxt = irq_cnt_r + count_t'(s1_cyc_r);
          end else begin
            irq_en_nxt   = 1'b0;
            irq_pend_nxt = 1'b1;
          end
        end
      end
      KIND_LOOKUP: begin
        if (s1_addr_r >= LOOKUP_LO) begin
          off_nxt  = map_offset(s1_addr_r, mode_r, sbank_r);
          offv_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r     <= 1'b0;
      out_v_r    <= 1'b0;
      mode_r     <= '0;
      sbank_r    <= '0;
      irq_en_r   <= 1'b0;
      irq_cnt_r  <= '0;
      irq_pend_r <= 1'b0;
    end else begin
      if (!in_stall) s1_v_r <= in_valid;
      out_v_r <= s1_go || (out_v_r && out_stall);
      if (s1_go) begin
        mode_r     <= mode_nxt;
        sbank_r    <= sbank_nxt;
        irq_en_r   <= irq_en_nxt;
        irq_cnt_r  <= irq_cnt_nxt;
        irq_pend_r <= irq_pend_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_kind_r <= in_kind;
      s1_addr_r <= in_bus_address;
      s1_data_r <= in_write_data;
      s1_cyc_r  <= in_cycle_count;
    end
    if (s1_go) begin
      off_r  <= off_nxt;
      offv_r <= offv_nxt;
    end
  end

  assign out_valid           = out_v_r;
  assign out_rom_offset      = off_r;
  assign out_offset_valid    = offv_r;
  // status fields follow the state as left by the item in the result register
  assign out_pattern_bank    = mode_r[2:1];
  assign out_mirror_vertical = ~mode_r[2];
  assign out_irq_line        = irq_pend_r;

endmodule
`default_nettype wire

// ===== src/cbmirq_checker.sv =====
`default_nettype none
`include "cartridge_bank_mapper_irq_unit_macros.svh"
module cbmirq_checker (
  input wire                 clk,
  input wire                 rst_n,
  input wire                 in_valid,
  input wire                 in_stall,
  input cbmirq_pkg::kind_t   in_kind,
  input cbmirq_pkg::addr_t   in_bus_address,
  input cbmirq_pkg::byte_t   in_write_data,
  input cbmirq_pkg::byte_t   in_cycle_count,
  input wire                 out_valid,
  input wire                 out_stall,
  input cbmirq_pkg::offset_t out_rom_offset,
  input wire                 out_offset_valid,
  input wire [1:0]           out_pattern_bank,
  input wire                 out_mirror_vertical,
  input wire                 out_irq_line
);
  import cbmirq_pkg::*;

  logic unused_ok;
  assign unused_ok = in_valid ^ (^in_kind) ^ (^in_bus_address) ^ (^in_write_data)
                     ^ (^in_cycle_count) ^ out_irq_line;

  // input side backs up only when the result side is full and held
  `CBMIRQ_ASSERT_IMP(a_stall_cause, in_stall, out_valid && out_stall)
  // no offset without a mapped lookup
  `CBMIRQ_ASSERT_IMP(a_offset_zero, out_valid && !out_offset_valid, out_rom_offset == '0)
  // mirror flag and pattern bank bit 1 both come from mode bit 2
  `CBMIRQ_ASSERT_IMP(a_mirror_mode, out_valid, out_mirror_vertical == !out_pattern_bank[1])
  `CBMIRQ_ASSERT_NXT(a_out_hold, out_valid && out_stall,
                     out_valid && $stable(out_rom_offset) && $stable(out_offset_valid))

endmodule

bind cartridge_bank_mapper_irq_unit cbmirq_checker u_cbmirq_checker (.*);
`default_nettype wire
